>>> design/bae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bae_pkg
// Shared constants and types of the binary arithmetic encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

  // Default coder geometry
  localparam int CODE_BITS    = 32;
  localparam int PROB_BITS    = 12;
  localparam int PENDING_BITS = 16;

  // Fixed payload field widths
  localparam int PROB_FIELD_W  = 12;
  localparam int COUNT_FIELD_W = 16;

  // Action codes of an input item
  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  // Decision of one renormalization step
  typedef struct packed {
    logic emit;  // range in lower or upper half: emit a group
    logic lead;  // lead bit of the emitted group
    logic pend;  // range in middle half: grow the pending count
  } norm_ctl_t;

endpackage : bae_pkg
`default_nettype wire

>>> design/bae_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bae_if
// Valid/ready channels of the encoder: input items and emitted groups.
// ----------------------------------------------------------------------------
interface bae_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic                              bit_value;
  logic [bae_pkg::PROB_FIELD_W-1:0]  prob_one;

  modport source (output valid, action, bit_value, prob_one, input ready);
  modport sink   (input valid, action, bit_value, prob_one, output ready);
endinterface : bae_in_if

interface bae_out_if;
  logic                              valid;
  logic                              ready;
  logic                              lead_bit;
  logic [bae_pkg::COUNT_FIELD_W-1:0] follow_count;
  logic                              overflow;
  logic                              last;

  modport source (output valid, lead_bit, follow_count, overflow, last, input ready);
  modport sink   (input valid, lead_bit, follow_count, overflow, last, output ready);
endinterface : bae_out_if
`default_nettype wire

>>> design/bae_split.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bae_split
// Registered multiplier: scaled range width times the probability.
// ----------------------------------------------------------------------------
module bae_split #(
  parameter int CODE_BITS = bae_pkg::CODE_BITS,
  parameter int PROB_BITS = bae_pkg::PROB_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             start,
  input  wire logic [CODE_BITS-1:0]             low,
  input  wire logic [CODE_BITS-1:0]             high,
  input  wire logic [bae_pkg::PROB_FIELD_W-1:0] prob_one,
  output logic      [CODE_BITS-1:0]             prod
);

  // Only the low PROB_BITS bits of the probability take part
  localparam int PW = (PROB_BITS < bae_pkg::PROB_FIELD_W) ? PROB_BITS
                                                           : bae_pkg::PROB_FIELD_W;

  logic [CODE_BITS-1:0]    span;
  logic [CODE_BITS-1:0]    scaled;
  logic [CODE_BITS+PW-1:0] prod_full;

  // Width of the range, scaled down by the probability resolution
  assign span      = high - low;
  assign scaled    = span >> PROB_BITS;
  assign prod_full = (CODE_BITS+PW)'(scaled) * (CODE_BITS+PW)'(prob_one[PW-1:0]);

  // Capture the product on a transfer
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= prod_full[CODE_BITS-1:0];
    end
  end

endmodule : bae_split
`default_nettype wire

>>> design/bae_norm_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bae_norm_step
// One renormalization step: half/quarter compare, shift and pending update.
// ----------------------------------------------------------------------------
module bae_norm_step #(
  parameter int CODE_BITS    = bae_pkg::CODE_BITS,
  parameter int PENDING_BITS = bae_pkg::PENDING_BITS
) (
  input  wire logic [CODE_BITS-1:0]    low,
  input  wire logic [CODE_BITS-1:0]    high,
  input  wire logic [PENDING_BITS-1:0] pending,
  input  wire logic                    ovf,
  output bae_pkg::norm_ctl_t           ctl,
  output logic      [CODE_BITS-1:0]    low_next,
  output logic      [CODE_BITS-1:0]    high_next,
  output logic      [PENDING_BITS-1:0] pending_next,
  output logic                         ovf_next
);

  localparam logic [CODE_BITS-1:0] QTR = {2'b01, {(CODE_BITS-2){1'b0}}};

  logic [CODE_BITS-1:0] low_sel;
  logic [CODE_BITS-1:0] high_sel;

  // Classify the range
  always_comb begin
    ctl = '0;
    priority if (!high[CODE_BITS-1]) begin
      ctl.emit = 1'b1;
      ctl.lead = 1'b0;
    end else if (low[CODE_BITS-1]) begin
      ctl.emit = 1'b1;
      ctl.lead = 1'b1;
    end else if (low[CODE_BITS-2] && !high[CODE_BITS-2]) begin
      ctl.pend = 1'b1;
    end else begin
      ctl.emit = 1'b0;
    end
  end

  // Fold the middle half outward, then shift in a 0 below and a 1 above
  always_comb begin
    low_sel  = ctl.pend ? (low ^ QTR) : low;
    high_sel = ctl.pend ? (high ^ QTR) : high;
    if (ctl.emit || ctl.pend) begin
      low_next  = {low_sel[CODE_BITS-2:0], 1'b0};
      high_next = {high_sel[CODE_BITS-2:0], 1'b1};
    end else begin
      low_next  = low;
      high_next = high;
    end
  end

  // Clear the count on emission, saturate it on underflow
  always_comb begin
    pending_next = pending;
    ovf_next     = ovf;
    if (ctl.emit) begin
      pending_next = '0;
    end else if (ctl.pend) begin
      if (&pending) begin
        ovf_next = 1'b1;
      end else begin
        pending_next = pending + PENDING_BITS'(1);
      end
    end
  end

endmodule : bae_norm_step
`default_nettype wire

>>> design/binary_arithmetic_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
// Binary arithmetic encoder with pending bits, one renormalization step per
// cycle while no emission waits for the output register.
// ----------------------------------------------------------------------------
// Usage:
//   enc_in carries one item per transfer: an encode item (bit_value and
//   prob_one) or a flush item that ends the stream. grp_out carries the
//   emitted groups: a lead bit followed by follow_count inverted bits, the
//   sticky overflow flag, and last on the final group of each item.
//   From its transfer to the next possible transfer an item passes these
//   steps: the transfer loads the multiplier, S_SPLIT sets the new bounds,
//   the shared step unit makes each renormalization step in S_NORM and then
//   finds the range settled, a flush emits its two closing groups in
//   S_FLUSH_A and S_FLUSH_B, and S_DONE releases the final group. enc_in
//   is ready only while the sequencer is idle.
//   One group is held back until the next one (or the end of the item) is
//   known, so last can be set; the held group then moves to the output
//   register. If the receiver stalls with the output register full, the
//   sequencer waits at the next emission that finds a group held, and in
//   S_DONE. An item that emits nothing gives no transfer on grp_out.
//   Reset sets the range to its full width, clears the pending count and
//   the overflow flag, and drops any group not yet transferred. A flush
//   restores the range and the pending count but keeps the overflow flag.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder #(
  parameter int CODE_BITS    = bae_pkg::CODE_BITS,
  parameter int PROB_BITS    = bae_pkg::PROB_BITS,
  parameter int PENDING_BITS = bae_pkg::PENDING_BITS
) (
  input wire logic  clk,
  input wire logic  rst,
  bae_in_if.sink    enc_in,
  bae_out_if.source grp_out
);

  localparam int FW = (PENDING_BITS < bae_pkg::COUNT_FIELD_W) ? PENDING_BITS
                                                               : bae_pkg::COUNT_FIELD_W;
  localparam logic [CODE_BITS-1:0] QTR = {2'b01, {(CODE_BITS-2){1'b0}}};

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SPLIT   = 3'd1;
  localparam logic [2:0] S_NORM    = 3'd2;
  localparam logic [2:0] S_FLUSH_A = 3'd3;
  localparam logic [2:0] S_FLUSH_B = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]              state;
  logic [CODE_BITS-1:0]    low;
  logic [CODE_BITS-1:0]    high;
  logic [PENDING_BITS-1:0] pending;
  logic                    ovf;
  logic                    act;
  logic                    bit_r;

  // Held group, waiting to learn whether it is the last one
  logic                    hold_valid;
  logic                    hold_lead;
  logic [FW-1:0]           hold_cnt;
  logic                    hold_ovf;

  // Output register
  logic                    out_valid;
  logic                    out_lead;
  logic [FW-1:0]           out_cnt;
  logic                    out_ovf;
  logic                    out_last;

  logic                    accept;
  logic                    slot_free;
  logic                    emit_ok;
  logic [CODE_BITS-1:0]    prod;
  logic [CODE_BITS-1:0]    mid;
  logic [CODE_BITS-1:0]    mid_p1;
  logic                    keep_low_part;

  bae_pkg::norm_ctl_t      ctl;
  logic [CODE_BITS-1:0]    low_step;
  logic [CODE_BITS-1:0]    high_step;
  logic [PENDING_BITS-1:0] pending_step;
  logic                    ovf_step;

  // Handshake
  assign enc_in.ready = (state == S_IDLE);
  assign accept       = enc_in.valid && enc_in.ready;
  assign slot_free    = !out_valid || grp_out.ready;
  assign emit_ok      = !hold_valid || slot_free;

  assign grp_out.valid        = out_valid;
  assign grp_out.lead_bit     = out_lead;
  assign grp_out.follow_count = bae_pkg::COUNT_FIELD_W'(out_cnt);
  assign grp_out.overflow     = out_ovf;
  assign grp_out.last         = out_last;

  // Range split
  bae_split #(
    .CODE_BITS (CODE_BITS),
    .PROB_BITS (PROB_BITS)
  ) u_split (
    .clk      (clk),
    .start    (accept),
    .low      (low),
    .high     (high),
    .prob_one (enc_in.prob_one),
    .prod     (prod)
  );

  assign mid    = low + prod;
  assign mid_p1 = low + prod + CODE_BITS'(1);
  assign keep_low_part = (act == bae_pkg::ACT_FLUSH) ? !mid[CODE_BITS-1] : bit_r;

  // Shared renormalization step
  bae_norm_step #(
    .CODE_BITS    (CODE_BITS),
    .PENDING_BITS (PENDING_BITS)
  ) u_step (
    .low          (low),
    .high         (high),
    .pending      (pending),
    .ovf          (ovf),
    .ctl          (ctl),
    .low_next     (low_step),
    .high_next    (high_step),
    .pending_next (pending_step),
    .ovf_next     (ovf_step)
  );

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= enc_in.action;
      bit_r <= enc_in.bit_value;
    end
  end

  // Sequencer, coder state and group hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      low        <= '0;
      high       <= '1;
      pending    <= '0;
      ovf        <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Drop the output once transferred
      if (grp_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (keep_low_part) begin
            high <= mid;
          end else begin
            low <= mid_p1;
          end
          state <= S_NORM;
        end
        S_NORM: begin
          if (ctl.emit) begin
            if (emit_ok) begin
              if (hold_valid) begin
                out_valid <= 1'b1;
                out_lead  <= hold_lead;
                out_cnt   <= hold_cnt;
                out_ovf   <= hold_ovf;
                out_last  <= 1'b0;
              end
              hold_valid <= 1'b1;
              hold_lead  <= ctl.lead;
              hold_cnt   <= pending[FW-1:0];
              hold_ovf   <= ovf;
              low        <= low_step;
              high       <= high_step;
              pending    <= pending_step;
              ovf        <= ovf_step;
            end
          end else if (ctl.pend) begin
            low     <= low_step;
            high    <= high_step;
            pending <= pending_step;
            ovf     <= ovf_step;
          end else begin
            state <= (act == bae_pkg::ACT_FLUSH) ? S_FLUSH_A : S_DONE;
          end
        end
        S_FLUSH_A, S_FLUSH_B: begin
          if (emit_ok) begin
            if (hold_valid) begin
              out_valid <= 1'b1;
              out_lead  <= hold_lead;
              out_cnt   <= hold_cnt;
              out_ovf   <= hold_ovf;
              out_last  <= 1'b0;
            end
            hold_valid <= 1'b1;
            hold_lead  <= (state == S_FLUSH_B) || (low > QTR);
            hold_cnt   <= pending[FW-1:0];
            hold_ovf   <= ovf;
            pending    <= '0;
            if (state == S_FLUSH_B) begin
              low   <= '0;
              high  <= '1;
              state <= S_DONE;
            end else begin
              state <= S_FLUSH_B;
            end
          end
        end
        S_DONE: begin
          // Release the final group of the item
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            out_valid  <= 1'b1;
            out_lead   <= hold_lead;
            out_cnt    <= hold_cnt;
            out_ovf    <= hold_ovf;
            out_last   <= 1'b1;
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : binary_arithmetic_encoder
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary arithmetic encoder. A predictor class
// tracks the code range and pending count, builds the groups each transfer
// on enc_in should cause, and checks every group transfer on grp_out in order.
// ----------------------------------------------------------------------------
module tb;
  import bae_pkg::*;

  localparam logic [CODE_BITS-1:0] HALF_PT   = {1'b1, {(CODE_BITS-1){1'b0}}};
  localparam logic [CODE_BITS-1:0] QTR_PT    = {2'b01, {(CODE_BITS-2){1'b0}}};
  localparam logic [CODE_BITS-1:0] THREE_QTR = {2'b11, {(CODE_BITS-2){1'b0}}};
  localparam logic [CODE_BITS-1:0] PROB_MASK = {CODE_BITS{1'b1}} >> (CODE_BITS - PROB_BITS);
  localparam logic [PENDING_BITS-1:0] PEND_MAX = '1;
  localparam int MAX_GROUPS    = CODE_BITS + 2;
  localparam int SETTLE_CYCLES = CODE_BITS + 8;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SAT_CAP       = 16;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int MAX_REPORTS   = 50;

  typedef struct packed {
    logic                     lead_bit;
    logic [COUNT_FIELD_W-1:0] follow_count;
    logic                     overflow;
    logic                     last;
  } code_group_t;

  typedef enum int {RX_OPEN, RX_SPARSE, RX_PATTERN, RX_COIN} rx_mode_t;

  // Predictor: own copy of the coder state and the groups still due
  class group_predictor;
    logic [CODE_BITS-1:0]    lo_bound;
    logic [CODE_BITS-1:0]    hi_bound;
    logic [PENDING_BITS-1:0] pend_cnt;
    logic                    ovf_flag;
    int unsigned             mismatches;
    code_group_t             groups_due[$];
    code_group_t             item_groups[$];

    function void restart();
      lo_bound   = '0;
      hi_bound   = '1;
      pend_cnt   = '0;
      ovf_flag   = 1'b0;
      mismatches = 0;
      groups_due.delete();
    endfunction

    function void push_group(logic lead);
      code_group_t g;
      if (item_groups.size() < MAX_GROUPS) begin
        g.lead_bit     = lead;
        g.follow_count = COUNT_FIELD_W'(pend_cnt);
        g.overflow     = ovf_flag;
        g.last         = 1'b0;
        item_groups.push_back(g);
      end
      pend_cnt = '0;
    endfunction

    // Shift the range out until it straddles the half point outside the middle
    function void rescale();
      for (int i = 0; i <= CODE_BITS + 1; i++) begin
        if (hi_bound < HALF_PT) begin
          push_group(1'b0);
        end else if (lo_bound >= HALF_PT) begin
          push_group(1'b1);
        end else if (lo_bound >= QTR_PT && hi_bound < THREE_QTR) begin
          if (pend_cnt == PEND_MAX) ovf_flag = 1'b1;
          else pend_cnt = pend_cnt + 1'b1;
          lo_bound = lo_bound ^ QTR_PT;
          hi_bound = hi_bound ^ QTR_PT;
        end else begin
          break;
        end
        lo_bound = lo_bound << 1;
        hi_bound = {hi_bound[CODE_BITS-2:0], 1'b1};
      end
    endfunction

    // Note one accepted item and queue the groups it causes
    function void accept_item(logic action_code, logic bit_value,
                              logic [PROB_FIELD_W-1:0] prob);
      logic [CODE_BITS-1:0] span;
      logic [CODE_BITS-1:0] mid;
      int                   n;
      item_groups.delete();
      span = hi_bound - lo_bound;
      mid  = lo_bound + (span >> PROB_BITS) * (CODE_BITS'(prob) & PROB_MASK);
      if (action_code == ACT_ENCODE) begin
        if (bit_value) hi_bound = mid;
        else lo_bound = mid + 1'b1;
        rescale();
      end else begin
        if (mid < HALF_PT) hi_bound = mid;
        else lo_bound = mid + 1'b1;
        rescale();
        if (lo_bound <= QTR_PT) begin
          push_group(1'b0);
          push_group(1'b1);
        end else begin
          push_group(1'b1);
          push_group(1'b1);
        end
        lo_bound = '0;
        hi_bound = '1;
        pend_cnt = '0;
      end
      n = item_groups.size();
      if (n > 0) item_groups[n-1].last = 1'b1;
      foreach (item_groups[i]) groups_due.push_back(item_groups[i]);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      if (mismatches < MAX_REPORTS)
        $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    endfunction

    // Compare one transferred group with the oldest one due
    function void check_group(code_group_t got);
      code_group_t want;
      if (groups_due.size() == 0) begin
        if (mismatches < MAX_REPORTS) $error("group transfer with none due");
        mismatches++;
        return;
      end
      want = groups_due.pop_front();
      if (got.lead_bit !== want.lead_bit)
        report("lead_bit", want.lead_bit, got.lead_bit);
      if (got.follow_count !== want.follow_count)
        report("follow_count", want.follow_count, got.follow_count);
      if (got.overflow !== want.overflow)
        report("overflow", want.overflow, got.overflow);
      if (got.last !== want.last)
        report("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_req;
  int unsigned cycle_cnt;
  group_predictor coder = new();

  bae_in_if  enc_if ();
  bae_out_if grp_if ();

  binary_arithmetic_encoder u_top (
    .clk     (clk),
    .rst     (rst),
    .enc_in  (enc_if),
    .grp_out (grp_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check every group transfer
  always @(posedge clk) begin
    if (!rst && grp_if.valid && grp_if.ready)
      coder.check_group({grp_if.lead_bit, grp_if.follow_count, grp_if.overflow, grp_if.last});
  end

  // Stall the receiver on its own pattern; hold off long on request
  initial begin : receiver
    rx_mode_t mode;
    int       stretch;
    int       phase;
    mode    = RX_OPEN;
    stretch = 0;
    phase   = 0;
    grp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        grp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_t'($urandom_range(0, 3));
          stretch = $urandom_range(10, 80);
        end
        stretch--;
        phase++;
        case (mode)
          RX_OPEN:    grp_if.ready <= 1'b1;
          RX_SPARSE:  grp_if.ready <= ($urandom_range(0, 3) == 0);
          RX_PATTERN: grp_if.ready <= (phase % 3 != 0);
          default:    grp_if.ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // Offer one item from a falling edge, hold it until transfer
  task automatic send_item(input logic act, input logic bv,
                           input logic [PROB_FIELD_W-1:0] prob);
    enc_if.valid     <= 1'b1;
    enc_if.action    <= act;
    enc_if.bit_value <= bv;
    enc_if.prob_one  <= prob;
    @(posedge clk);
    while (!enc_if.ready) @(posedge clk);
    coder.accept_item(act, bv, prob);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic                    act;
    logic                    bv;
    logic [PROB_FIELD_W-1:0] prob;
    act = ($urandom_range(0, 19) == 0) ? ACT_FLUSH : ACT_ENCODE;
    bv  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       prob = '0;
      1:       prob = '1;
      2:       prob = PROB_FIELD_W'($urandom_range(1, 15));
      default: prob = PROB_FIELD_W'($urandom);
    endcase
    send_item(act, bv, prob);
  endtask

  // Random items in bursts with random gaps
  task automatic offer_stream(input int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if ($urandom_range(0, 2) != 0) begin
          enc_if.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
        end
      end
      burst--;
      send_random();
    end
  endtask

  // Pause the sender until every due group has arrived or DRAIN_LIMIT runs out
  task automatic settle();
    enc_if.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && coder.groups_due.size() != 0; i++)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    longint lo_now;
    longint step_g;
    longint k;
    logic   sat_bit;
    int     sat_items;
    logic [CODE_BITS-1:0] width_now;

    cycle_cnt = 0;
    hold_req  = 1'b0;
    coder.restart();
    rst              <= 1'b1;
    enc_if.valid     <= 1'b0;
    enc_if.action    <= ACT_ENCODE;
    enc_if.bit_value <= 1'b0;
    enc_if.prob_one  <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, collapsed range, both flush outcomes
    send_item(ACT_ENCODE, 1'b0, '0);
    send_item(ACT_ENCODE, 1'b1, '1);
    send_item(ACT_ENCODE, 1'b0, '1);
    send_item(ACT_ENCODE, 1'b1, 12'd2048);
    send_item(ACT_ENCODE, 1'b0, 12'd2048);
    send_item(ACT_ENCODE, 1'b1, '0);
    send_item(ACT_ENCODE, 1'b1, 12'd1);
    send_item(ACT_ENCODE, 1'b0, 12'd4094);
    send_item(ACT_FLUSH,  1'b0, 12'd2048);
    settle();
    send_item(ACT_FLUSH,  1'b1, '0);
    send_item(ACT_FLUSH,  1'b0, '1);
    send_item(ACT_ENCODE, 1'b0, 12'hAAA);
    send_item(ACT_ENCODE, 1'b1, 12'h555);
    send_item(ACT_ENCODE, 1'b1, '0);
    send_item(ACT_FLUSH,  1'b1, 12'd3000);
    send_item(ACT_ENCODE, 1'b0, 12'd1);
    send_item(ACT_FLUSH,  1'b0, 12'd1);
    settle();

    // Long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    offer_stream(24);

    offer_stream(180);
    settle();
    offer_stream(180);

    // Keep the range around the half point to build a long pending run
    sat_items = 0;
    while (!coder.ovf_flag && sat_items < SAT_CAP) begin
      width_now = coder.hi_bound - coder.lo_bound;
      step_g    = longint'(width_now >> PROB_BITS);
      lo_now    = longint'(coder.lo_bound);
      if (step_g == 0) begin
        send_random();
      end else begin
        if (coder.hi_bound >= THREE_QTR) begin
          k       = (longint'(HALF_PT) - lo_now + step_g - 1) / step_g;
          sat_bit = 1'b1;
        end else begin
          k       = (longint'(HALF_PT) - 2 - lo_now) / step_g;
          sat_bit = 1'b0;
        end
        if (k < 0) k = 0;
        if (k > 4095) k = 4095;
        send_item(ACT_ENCODE, sat_bit, PROB_FIELD_W'(k));
      end
      sat_items++;
    end
    // Emit the pending run, then end the stream with a flush
    send_item(ACT_ENCODE, 1'b1, '0);
    offer_stream(10);
    send_item(ACT_FLUSH, 1'b0, 12'd2048);

    settle();
    if (coder.groups_due.size() != 0) begin
      $error("%0d groups never arrived", coder.groups_due.size());
      coder.mismatches++;
    end
    if (coder.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
